@@ hw/rtl/usb_td_chain_status_checker_assert.svh @@
// Assertion macros used by the checker module of the descriptor checker.
`ifndef USB_TD_CHAIN_STATUS_CHECKER_ASSERT_SVH
`define USB_TD_CHAIN_STATUS_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USBTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define USBTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/usbtd_pkg.sv @@
// ----------------------------------------------------------------------------
// usbtd_pkg
// Shared widths, field offsets and codes of the descriptor status checker.
// ----------------------------------------------------------------------------
package usbtd_pkg;

    localparam int MAX_DESCRIPTORS_DEF = 256;

    localparam int FLAGS_W = 7;
    localparam int LEN_W   = 11;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 9;
    localparam int SUM_W   = 19;

    // Input tdata layout, lowest bit first.
    localparam int IN_FLAGS_LSB = 0;
    localparam int IN_ENC_LSB   = IN_FLAGS_LSB + FLAGS_W;
    localparam int IN_MAXP_LSB  = IN_ENC_LSB + LEN_W;
    localparam int IN_USED_W    = IN_MAXP_LSB + LEN_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_DONE_LSB  = 0;
    localparam int OUT_FLAGS_LSB = OUT_DONE_LSB + 1;
    localparam int OUT_POS_LSB   = OUT_FLAGS_LSB + FLAGS_W;
    localparam int OUT_SUM_LSB   = OUT_POS_LSB + POS_W;
    localparam int OUT_FLIP_LSB  = OUT_SUM_LSB + SUM_W;
    localparam int OUT_USED_W    = OUT_FLIP_LSB + 1;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // Packet kinds. Kind three behaves like an output packet.
    localparam logic [KIND_W-1:0] KIND_SETUP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INPUT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OUTPUT = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SPEED        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_TRANSFER = 1'd1;

endpackage

@@ hw/rtl/usb_td_chain_status_checker.sv @@
// Result: registered; a result appears on m_tdata in the cycle after its last descriptor is accepted.
// Throughput: one descriptor per cycle; the single result register holds a stalled
// result and s_tready drops only while that register is full and not being taken.
// Reset: rst_n clears the configuration, the per-transfer state and the result valid.
// Configuration writes are always ready and take effect on the next descriptor.
// ----------------------------------------------------------------------------
// usb_td_chain_status_checker
// Checks the status of a chain of transfer descriptors and reports one result
// per transfer: completion, failing flags, stop position, byte total, toggle.
// ----------------------------------------------------------------------------
module usb_td_chain_status_checker #(
    parameter int MAX_DESCRIPTORS = usbtd_pkg::MAX_DESCRIPTORS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tdata: still_active, stalled, buffer_error, babble, nak_seen, crc_timeout,
    // bitstuff_error, encoded_length[10:0], max_packet_length[10:0], zero pad
    input  logic [usbtd_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: packet_kind[1:0]
    input  logic [usbtd_pkg::KIND_W-1:0]         s_tuser,
    input  logic                                 s_tlast,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: completed, error_flags[6:0], error_position[8:0], total_length[18:0],
    // toggle_flip, zero pad
    output logic [usbtd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [usbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                                 cfg_data
);

    localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);
    localparam int EXT_W = (CNT_W > usbtd_pkg::POS_W) ? CNT_W : usbtd_pkg::POS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DESCRIPTORS);

    logic                             low_speed_reg;
    logic                             control_reg;

    logic [usbtd_pkg::FLAGS_W-1:0]    flags_reg, flags_next;
    logic                             stopped_reg, stopped_next;
    logic [CNT_W-1:0]                 stop_pos_reg, stop_pos_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [usbtd_pkg::SUM_W-1:0]      sum_reg, sum_next;

    logic                             out_valid_reg;
    logic [usbtd_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [usbtd_pkg::FLAGS_W-1:0]    in_flags;
    logic [usbtd_pkg::LEN_W-1:0]      in_enc;
    logic [usbtd_pkg::LEN_W-1:0]      in_maxp;
    logic [usbtd_pkg::LEN_W-1:0]      dec_len;
    logic [usbtd_pkg::SUM_W:0]        sum_wide;
    logic                             short_pkt;
    logic                             accept;

    logic [CNT_W-1:0]                 errpos;
    logic [EXT_W-1:0]                 errpos_ext;
    logic                             flip;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign in_flags = s_tdata[usbtd_pkg::IN_FLAGS_LSB +: usbtd_pkg::FLAGS_W];
    assign in_enc   = s_tdata[usbtd_pkg::IN_ENC_LSB +: usbtd_pkg::LEN_W];
    assign in_maxp  = s_tdata[usbtd_pkg::IN_MAXP_LSB +: usbtd_pkg::LEN_W];

    // The length field is n-1 encoded; all ones wraps to zero bytes.
    assign dec_len   = in_enc + usbtd_pkg::LEN_W'(1);
    assign sum_wide  = {1'b0, sum_reg} + (usbtd_pkg::SUM_W + 1)'(dec_len);
    assign short_pkt = !low_speed_reg && (s_tuser == usbtd_pkg::KIND_INPUT)
                       && (dec_len < in_maxp);

    always_comb
    begin
        flags_next    = flags_reg;
        stopped_next  = stopped_reg;
        stop_pos_next = stop_pos_reg;
        sum_next      = sum_reg;
        count_next    = (count_reg < CNT_MAX) ? count_reg + CNT_W'(1) : count_reg;

        if (!stopped_reg)
        begin
            if (in_flags != '0)
            begin
                flags_next    = in_flags;
                stopped_next  = 1'b1;
                stop_pos_next = count_reg;
            end
            else
            begin
                if (s_tuser != usbtd_pkg::KIND_SETUP)
                begin
                    sum_next = sum_wide[usbtd_pkg::SUM_W] ? '1
                                                          : sum_wide[usbtd_pkg::SUM_W-1:0];
                end
                if (short_pkt)
                begin
                    stopped_next  = 1'b1;
                    stop_pos_next = count_reg;
                end
            end
        end
    end

    // Result fields are taken from the state as it stands after this descriptor.
    assign errpos     = stopped_next ? stop_pos_next : count_next;
    assign errpos_ext = EXT_W'(errpos);
    assign flip       = (flags_next != '0) && !control_reg && (count_next[0] ^ errpos[0]);

    always_comb
    begin
        out_data_next = '0;
        out_data_next[usbtd_pkg::OUT_DONE_LSB] = (flags_next == '0);
        out_data_next[usbtd_pkg::OUT_FLAGS_LSB +: usbtd_pkg::FLAGS_W] = flags_next;
        out_data_next[usbtd_pkg::OUT_POS_LSB +: usbtd_pkg::POS_W] =
            errpos_ext[usbtd_pkg::POS_W-1:0];
        out_data_next[usbtd_pkg::OUT_SUM_LSB +: usbtd_pkg::SUM_W] = sum_next;
        out_data_next[usbtd_pkg::OUT_FLIP_LSB] = flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_speed_reg <= 1'b0;
            control_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                usbtd_pkg::CFG_LOW_SPEED:        low_speed_reg <= cfg_data;
                usbtd_pkg::CFG_CONTROL_TRANSFER: control_reg   <= cfg_data;
                default:                         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            stopped_reg  <= 1'b0;
            stop_pos_reg <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // The transfer ends here; start clean for the next one.
                flags_reg    <= '0;
                stopped_reg  <= 1'b0;
                stop_pos_reg <= '0;
                count_reg    <= '0;
                sum_reg      <= '0;
            end
            else
            begin
                flags_reg    <= flags_next;
                stopped_reg  <= stopped_next;
                stop_pos_reg <= stop_pos_next;
                count_reg    <= count_next;
                sum_reg      <= sum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ hw/rtl/usbtd_checker.sv @@
// ----------------------------------------------------------------------------
// usbtd_checker
// Port-level assertions for the descriptor status checker, bound to the top.
// ----------------------------------------------------------------------------
`include "usb_td_chain_status_checker_assert.svh"

module usbtd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tlast,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [usbtd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    logic                          res_done;
    logic [usbtd_pkg::FLAGS_W-1:0] res_flags;
    logic                          res_flip;

    assign res_done  = m_tdata[usbtd_pkg::OUT_DONE_LSB];
    assign res_flags = m_tdata[usbtd_pkg::OUT_FLAGS_LSB +: usbtd_pkg::FLAGS_W];
    assign res_flip  = m_tdata[usbtd_pkg::OUT_FLIP_LSB];

    // A transfer is complete exactly when no status flag was captured.
    `USBTD_ASSERT_NOW(a_done_vs_flags, clk, rst_n, m_tvalid,
        res_done == (res_flags == '0), "completed disagrees with error_flags")

    // The toggle is only rolled back after an error.
    `USBTD_ASSERT_NOW(a_flip_needs_error, clk, rst_n, m_tvalid && res_flip,
        !res_done, "toggle_flip set on a completed transfer")

    // The last descriptor of a transfer yields its result in the next cycle.
    `USBTD_ASSERT_NEXT(a_last_gives_result, clk, rst_n, s_tvalid && s_tready && s_tlast,
        m_tvalid, "no result after the last descriptor")

    // A stalled result holds its value until the transaction completes.
    `USBTD_ASSERT_NEXT(a_result_holds, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind usb_td_chain_status_checker usbtd_checker u_usbtd_checker (.*);
